/* src/upw_pkg.sv */
// Shared types, register indexes and arithmetic helpers of the upwind advection block.
package upw_pkg;

    // Default grid limits along x and y.
    localparam int MAX_ROW_DEF  = 128;
    localparam int MAX_ROWS_DEF = 128;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COURANT_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COURANT_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COURANT_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_ROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_PLANE = 3'd4;

    // Axis numbering inside the update sequencer.
    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    // Width of the exact update sum: scalar plus three 50-bit terms.
    localparam int ACC_W = 52;
    // Width of a rounded product.
    localparam int RND_W = 50;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

    // Sequencer states of the update engine.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_CV,
        ST_RND_CV,
        ST_MUL_TERM,
        ST_RND_TERM,
        ST_SUM,
        ST_DONE
    } t_state;

    // Configuration registers as seen by the engine and the ring.
    typedef struct packed {
        logic [2:0][31:0] courant;
        logic [7:0]       cells_per_row;
        logic [7:0]       rows_per_plane;
    } t_cfg;

    // Ring access issued when an item is accepted.
    typedef struct packed {
        logic               wr;
        logic signed [31:0] scalar;
    } t_ring_req;

    // Neighbor scalars, registered and returned in the cycle after the access.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_ring_rsp;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] res;
        if (x > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

/* src/upw_ring.sv */
// Plane-deep scalar ring: write pointer, neighbor address generation and storage.
module upw_ring #(
    parameter int MAX_ROW  = upw_pkg::MAX_ROW_DEF,
    parameter int MAX_ROWS = upw_pkg::MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upw_pkg::t_cfg     i_cfg,
    input  upw_pkg::t_ring_req i_req,
    output upw_pkg::t_ring_rsp o_rsp
);
    import upw_pkg::*;

    localparam int DEPTH = MAX_ROW * MAX_ROWS;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int NX_W  = $clog2(MAX_ROW + 1);
    localparam int NY_W  = $clog2(MAX_ROWS + 1);
    localparam int PL_W  = NX_W + NY_W;
    localparam int AD_W  = PTR_W + 2;

    logic [PTR_W-1:0]   r_ptr;
    logic [PTR_W-1:0]   n_ptr;
    logic [NX_W-1:0]    nx;
    logic [NY_W-1:0]    ny;
    logic [PL_W-1:0]    plane;
    logic [PTR_W-1:0]   addr_y;
    logic [PTR_W-1:0]   addr_z;
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_last;
    logic signed [31:0] r_rd_x;
    logic signed [31:0] r_rd_y;
    logic signed [31:0] r_rd_z;

    // Entry that lies a given number of cells behind the write pointer, wrapping at the depth.
    function automatic logic [PTR_W-1:0] back_addr(input logic [PTR_W-1:0] ptr,
                                                   input logic [AD_W-1:0]  back);
        logic [AD_W-1:0] diff;
        diff = AD_W'(ptr) - back;
        if (diff[AD_W-1]) begin
            diff = diff + AD_W'(DEPTH);
        end
        return diff[PTR_W-1:0];
    endfunction

    // Clamp the grid dimensions; zero acts as one.
    always_comb begin
        if (i_cfg.cells_per_row == 8'd0) begin
            nx = NX_W'(1);
        end else if (int'(i_cfg.cells_per_row) > MAX_ROW) begin
            nx = NX_W'(MAX_ROW);
        end else begin
            nx = NX_W'(i_cfg.cells_per_row);
        end
        if (i_cfg.rows_per_plane == 8'd0) begin
            ny = NY_W'(1);
        end else if (int'(i_cfg.rows_per_plane) > MAX_ROWS) begin
            ny = NY_W'(MAX_ROWS);
        end else begin
            ny = NY_W'(i_cfg.rows_per_plane);
        end
    end

    assign plane  = PL_W'(nx) * PL_W'(ny);
    assign addr_y = back_addr(r_ptr, AD_W'(nx));
    assign addr_z = back_addr(r_ptr, AD_W'(plane));
    assign n_ptr  = (r_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;

    // Write pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_req.wr) begin
            r_ptr <= n_ptr;
        end
    end

    // Storage: neighbors are read before the item's own scalar lands.
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[r_ptr] <= i_req.scalar;
            r_rd_y       <= r_mem[addr_y];
            r_rd_z       <= r_mem[addr_z];
        end
    end

    // The x neighbor is always the most recently written scalar.
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_rd_x <= r_last;
            r_last <= i_req.scalar;
        end
    end

    assign o_rsp.x = r_rd_x;
    assign o_rsp.y = r_rd_y;
    assign o_rsp.z = r_rd_z;

endmodule

/* src/upw_engine.sv */
// Update engine: input handshake, sequencer, shared multiplier, rounding and output register.
module upw_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upw_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_scalar_in,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic               i_interior,
    output upw_pkg::t_ring_req o_ring_req,
    input  upw_pkg::t_ring_rsp i_ring_rsp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_scalar_out,
    output logic               o_updated
);
    import upw_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic [1:0]               r_axis;
    logic                     accept;
    logic                     out_free;
    logic                     load_out;
    logic signed [31:0]       r_s;
    logic signed [31:0]       r_v [3];
    logic signed [32:0]       r_d [3];
    logic                     r_upd;
    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       r_prod;
    logic signed [65:0]       rnd_sum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [31:0]       r_cv;
    logic signed [RND_W-1:0]  r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [31:0]       r_out_scalar;
    logic                     r_out_upd;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Every accepted item enters the ring.
    assign o_ring_req.wr     = accept;
    assign o_ring_req.scalar = i_scalar_in;

    // Next state and handshake.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = i_interior ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD:     n_state = ST_MUL_CV;
            ST_MUL_CV:   n_state = ST_RND_CV;
            ST_RND_CV:   n_state = ST_MUL_TERM;
            ST_MUL_TERM: n_state = ST_RND_TERM;
            ST_RND_TERM: n_state = ST_SUM;
            ST_SUM:      n_state = (r_axis == AXIS_LAST) ? ST_DONE : ST_MUL_CV;
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // State register and axis counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= AXIS_FIRST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOAD) begin
                r_axis <= AXIS_FIRST;
            end else if (r_state == ST_SUM && r_axis != AXIS_LAST) begin
                r_axis <= r_axis + 2'd1;
            end
        end
    end

    // Shared multiplier: coefficient times velocity, then cv times difference.
    always_comb begin
        if (r_state == ST_MUL_CV) begin
            mul_a = $signed({1'b0, i_cfg.courant[r_axis]});
            mul_b = 33'(r_v[r_axis]);
        end else begin
            mul_a = 33'(r_cv);
            mul_b = r_d[r_axis];
        end
    end

    // Round half up from Q32.32 to Q16.16.
    assign rnd_sum = r_prod + 66'sd32768;
    assign rnd     = $signed(rnd_sum[65:16]);

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_s    <= i_scalar_in;
                    r_v[0] <= i_vel_x;
                    r_v[1] <= i_vel_y;
                    r_v[2] <= i_vel_z;
                    r_upd  <= i_interior;
                end
            end
            ST_LOAD: begin
                r_d[0] <= 33'(r_s) - 33'(i_ring_rsp.x);
                r_d[1] <= 33'(r_s) - 33'(i_ring_rsp.y);
                r_d[2] <= 33'(r_s) - 33'(i_ring_rsp.z);
                r_acc  <= ACC_W'(r_s);
            end
            ST_MUL_CV, ST_MUL_TERM: begin
                r_prod <= mul_a * mul_b;
            end
            ST_RND_CV: begin
                r_cv <= sat32(ACC_W'(rnd));
            end
            ST_RND_TERM: begin
                r_term <= rnd;
            end
            ST_SUM: begin
                r_acc <= r_acc - ACC_W'(r_term);
            end
            default: begin
            end
        endcase
    end

    // Output register, so a new item can be taken while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_scalar <= r_upd ? sat32(r_acc) : 32'sd0;
            r_out_upd    <= r_upd;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scalar_out = r_out_scalar;
    assign o_updated    = r_out_upd;

    // A boundary item goes straight to the result stage, flagged as not updated.
    a_boundary_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_interior) |=> (r_state == ST_DONE && !r_upd))
        else $error("boundary item did not go straight to the result stage");

    // An interior item reads its neighbors and then starts on the first axis.
    a_interior_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_interior) |=> r_state == ST_LOAD ##1
        (r_state == ST_MUL_CV && r_axis == AXIS_FIRST))
        else $error("interior item did not start on the first axis");

    // The last axis sum hands over to the result stage.
    a_last_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && r_axis == AXIS_LAST) |=> r_state == ST_DONE)
        else $error("sequencer ran past the last axis");

    // A finished result waits while the output register is still occupied.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready) |=>
        (r_state == ST_DONE && r_out_valid))
        else $error("result stage left while the output register was full");

endmodule

/* src/upwind_advection_stencil_3d.sv */
// Top level of the 3D first-order upwind advection stencil.
//
// Grid cells arrive on the input channel (i_in_valid / o_in_ready) in raster
// order, x fastest. Each item carries the scalar, three velocities and an
// interior flag; exactly one result item leaves on o_out_valid / i_out_ready.
// A ring of one plane of scalars in a single memory supplies the y and z
// neighbors; the x neighbor is the previously accepted scalar.
// Sequence: a boundary item goes from acceptance straight to the result stage,
// which loads the output register before the return to idle. An interior
// item first reads its neighbors from memory, then for each axis takes two
// products and two roundings on the single shared 33x33 multiplier plus the
// sum, then loads the output register and returns to idle; new items are
// accepted only in idle.
// Results go to an output register, so a new item is accepted while the
// previous result still waits; if the receiver stalls, the sequencer holds
// the next result and stops taking items until the register frees.
// Configuration writes on i_cfg_valid are always taken (o_cfg_ready is high).
// Reset clears the write pointer, the sequencer and the output valid, and
// restores the registers to their defaults; the ring contents stay undefined
// and need no clearing pass.
module upwind_advection_stencil_3d #(
    parameter int MAX_ROW  = upw_pkg::MAX_ROW_DEF,
    parameter int MAX_ROWS = upw_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [upw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_scalar_in,
    input  logic signed [31:0]            i_vel_x,
    input  logic signed [31:0]            i_vel_y,
    input  logic signed [31:0]            i_vel_z,
    input  logic                          i_interior,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_scalar_out,
    output logic                          o_updated
);
    import upw_pkg::*;

    t_cfg      r_cfg;
    t_ring_req ring_req;
    t_ring_rsp ring_rsp;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.courant        <= '0;
            r_cfg.cells_per_row  <= 8'd128;
            r_cfg.rows_per_plane <= 8'd128;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COURANT_X:      r_cfg.courant[0]     <= i_cfg_data;
                CFG_COURANT_Y:      r_cfg.courant[1]     <= i_cfg_data;
                CFG_COURANT_Z:      r_cfg.courant[2]     <= i_cfg_data;
                CFG_CELLS_PER_ROW:  r_cfg.cells_per_row  <= i_cfg_data[7:0];
                CFG_ROWS_PER_PLANE: r_cfg.rows_per_plane <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Plane ring holding the neighbor scalars.
    upw_ring #(
        .MAX_ROW  (MAX_ROW),
        .MAX_ROWS (MAX_ROWS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (ring_req),
        .o_rsp   (ring_rsp)
    );

    // Update sequencer and output stage.
    upw_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_scalar_in  (i_scalar_in),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .i_interior   (i_interior),
        .o_ring_req   (ring_req),
        .i_ring_rsp   (ring_rsp),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scalar_out (o_scalar_out),
        .o_updated    (o_updated)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the 3D first-order upwind advection stencil.
module testbench;
    import upw_pkg::*;

    localparam int     HALF_PERIOD    = 6;
    localparam int     RING_DEPTH     = MAX_ROW_DEF * MAX_ROWS_DEF;
    localparam int     IDLE_PCT       = 26;
    localparam int     MAX_GAP        = 24;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     PRESSURE_CELLS = 96;
    localparam int     PHASE_CELLS    = 130;
    localparam int     PHASE_COUNT    = 10;
    localparam longint TIMEOUT_CYCLES = 3_000_000;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic [31:0]        C_MAX = 32'hFFFF_FFFF;

    // One grid cell as offered on the input channel.
    typedef struct packed {
        logic signed [31:0] scalar;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               interior;
    } t_cell;

    // One result item.
    typedef struct packed {
        logic signed [31:0] scalar;
        logic               updated;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [31:0]   i_scalar_in = '0;
    logic signed [31:0]   i_vel_x = '0;
    logic signed [31:0]   i_vel_y = '0;
    logic signed [31:0]   i_vel_z = '0;
    logic                 i_interior = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [31:0]   o_scalar_out;
    logic                 o_updated;

    // Mirror of the block's registers and scalar ring.
    logic [31:0]        cfg_cx = '0;
    logic [31:0]        cfg_cy = '0;
    logic [31:0]        cfg_cz = '0;
    logic [7:0]         cfg_cells = 8'd128;
    logic [7:0]         cfg_rows = 8'd128;
    logic signed [31:0] ring_scalar [RING_DEPTH];
    bit                 ring_filled [RING_DEPTH];
    int                 ring_wr_ptr = 0;

    t_result pending_results[$];
    int      fail_count = 0;
    bit      no_idle = 1'b0;
    bit      hold_request = 1'b0;

    upwind_advection_stencil_3d i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_scalar_in  (i_scalar_in),
        .i_vel_x      (i_vel_x),
        .i_vel_y      (i_vel_y),
        .i_vel_z      (i_vel_z),
        .i_interior   (i_interior),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scalar_out (o_scalar_out),
        .o_updated    (o_updated)
    );

    // Clock generation.
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Clip a wide value to signed 32 bits.
    function automatic longint clip_q16(input longint x);
        if (x > longint'(Q_MAX)) begin
            return longint'(Q_MAX);
        end
        if (x < longint'(Q_MIN)) begin
            return longint'(Q_MIN);
        end
        return x;
    endfunction

    // Zero acts as one, and sizes above the ring limit stick at the limit.
    function automatic int grid_dim(input logic [7:0] v, input int maxv);
        if (v == 8'd0) begin
            return 1;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic int ring_back(input int back);
        return (ring_wr_ptr + RING_DEPTH - back) % RING_DEPTH;
    endfunction

    // Coefficient times velocity, rounded half up and clipped, then times the difference.
    function automatic longint axis_term(input logic [31:0] c, input logic signed [31:0] v,
                                         input longint d);
        longint cv;
        cv = clip_q16((longint'(c) * longint'(v) + 64'sd32768) >>> 16);
        return (cv * d + 64'sd32768) >>> 16;
    endfunction

    // True when all three upwind neighbors of the next cell hold a written scalar.
    function automatic bit neighbors_ready();
        int nx;
        int ny;
        nx = grid_dim(cfg_cells, MAX_ROW_DEF);
        ny = grid_dim(cfg_rows, MAX_ROWS_DEF);
        return ring_filled[ring_back(1)] && ring_filled[ring_back(nx)]
               && ring_filled[ring_back(nx * ny)];
    endfunction

    // Upwind update of one accepted cell; the cell's scalar then enters the ring.
    function automatic t_result advect_cell(input t_cell c);
        t_result res;
        longint  s;
        longint  acc;
        int      nx;
        int      ny;
        nx  = grid_dim(cfg_cells, MAX_ROW_DEF);
        ny  = grid_dim(cfg_rows, MAX_ROWS_DEF);
        res = '0;
        if (c.interior) begin
            s   = longint'(c.scalar);
            acc = s - axis_term(cfg_cx, c.vel_x, s - longint'(ring_scalar[ring_back(1)]))
                    - axis_term(cfg_cy, c.vel_y, s - longint'(ring_scalar[ring_back(nx)]))
                    - axis_term(cfg_cz, c.vel_z,
                                s - longint'(ring_scalar[ring_back(nx * ny)]));
            res.scalar  = 32'(clip_q16(acc));
            res.updated = 1'b1;
        end
        ring_scalar[ring_wr_ptr] = c.scalar;
        ring_filled[ring_wr_ptr] = 1'b1;
        ring_wr_ptr = (ring_wr_ptr + 1) % RING_DEPTH;
        return res;
    endfunction

    function automatic t_cell make_cell(input logic signed [31:0] s, input logic signed [31:0] vx,
                                        input logic signed [31:0] vy, input logic signed [31:0] vz,
                                        input logic inner);
        t_cell c;
        c.scalar   = s;
        c.vel_x    = vx;
        c.vel_y    = vy;
        c.vel_z    = vz;
        c.interior = inner;
        return c;
    endfunction

    // Mix of extremes, raw random words and small magnitudes.
    function automatic logic signed [31:0] random_q(input int unsigned small_max);
        logic signed [31:0] mag;
        mag = $urandom_range(small_max);
        case ($urandom_range(9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $urandom_range(1) ? -mag : mag;
        endcase
    endfunction

    function automatic logic [31:0] random_courant();
        case ($urandom_range(7))
            0:       return '0;
            1:       return C_MAX;
            2, 3:    return $urandom;
            default: return $urandom_range(32'h0001_0000);
        endcase
    endfunction

    // Grid size with junk in the upper bits, which the register drops.
    function automatic logic [31:0] random_dim_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0:       w[7:0] = 8'd0;
            1:       w[7:0] = 8'd1;
            2:       w[7:0] = 8'd128;
            3:       w[7:0] = 8'd255;
            4:       w[7:0] = 8'($urandom_range(129, 254));
            default: w[7:0] = 8'($urandom_range(2, 12));
        endcase
        return w;
    endfunction

    function automatic t_cell random_cell(input int interior_pct);
        return make_cell(random_q(32'h0010_0000), random_q(32'h0004_0000),
                         random_q(32'h0004_0000), random_q(32'h0004_0000),
                         $urandom_range(99) < interior_pct);
    endfunction

    // Write one register; the predictor follows on acceptance.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_COURANT_X:      cfg_cx = data;
            CFG_COURANT_Y:      cfg_cy = data;
            CFG_COURANT_Z:      cfg_cz = data;
            CFG_CELLS_PER_ROW:  cfg_cells = data[7:0];
            CFG_ROWS_PER_PLANE: cfg_rows = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] cells_word,
                              input logic [31:0] rows_word);
        write_reg(CFG_COURANT_X, cx);
        write_reg(CFG_COURANT_Y, cy);
        write_reg(CFG_COURANT_Z, cz);
        write_reg(CFG_CELLS_PER_ROW, cells_word);
        write_reg(CFG_ROWS_PER_PLANE, rows_word);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one cell, possibly after a gap, and record its expected result on acceptance.
    task automatic offer_cell(input t_cell c);
        // An interior cell must never reach an entry that was never written.
        if (c.interior && !neighbors_ready()) begin
            c.interior = 1'b0;
        end
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_scalar_in <= c.scalar;
        i_vel_x     <= c.vel_x;
        i_vel_y     <= c.vel_y;
        i_vel_z     <= c.vel_z;
        i_interior  <= c.interior;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(advect_cell(c));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Default registers right after reset: boundary cells only, nothing is written yet.
    task automatic test_reset_state();
        repeat (4) offer_cell(random_cell(0));
        wait_drained();
    endtask

    // Extremes of every field, rounding ties, saturation and clamped grid sizes.
    task automatic test_directed_cases();
        // Grid sizes of zero act as one: every neighbor is the previous cell.
        set_config(32'h0000_8000, 32'h0000_0000, C_MAX, 32'hFFFF_FF00, 32'h0000_0000);
        offer_cell(make_cell('0, Q_MAX, Q_MIN, '0, 1'b0));
        offer_cell(make_cell(32'sd1, 32'sd1, 32'sd1, -32'sd1, 1'b1));
        offer_cell(make_cell(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b1));
        offer_cell(make_cell(Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1));
        offer_cell(make_cell(Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b1));
        offer_cell(make_cell(Q_MIN, $urandom, $urandom, $urandom, 1'b0));
        offer_cell(make_cell(-32'sd1, -32'sd1, '0, '0, 1'b1));
        offer_cell(make_cell(32'sh0001_8000, 32'sh0002_0000, -32'sh0000_8000, 32'sd1, 1'b1));
        wait_drained();

        // Largest coefficients on a two-cell row.
        set_config(C_MAX, C_MAX, C_MAX, 32'hABCD_EF02, 32'h1234_5600);
        offer_cell(make_cell(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
        offer_cell(make_cell(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        offer_cell(make_cell('0, 32'sd1, 32'sd1, 32'sd1, 1'b1));
        offer_cell(make_cell(Q_MAX, '0, '0, '0, 1'b0));
        offer_cell(make_cell(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1));
        wait_drained();

        // Indexes past the register list must change nothing.
        for (int k = int'(CFG_ROWS_PER_PLANE) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), $urandom);
        end
        // Zero coefficients leave the scalar as it is.
        set_config('0, '0, '0, 32'h0000_0001, 32'hFFFF_FF03);
        repeat (4) offer_cell(random_cell(100));
        wait_drained();
    endtask

    // Long receiver hold-off on a small grid while cells keep coming, so the input stalls.
    task automatic test_stall_pressure();
        set_config($urandom_range(32'h0000_8000), $urandom_range(32'h0000_8000),
                   $urandom_range(32'h0000_8000), 32'h0000_0008, 32'h0000_0004);
        no_idle = 1'b1;
        for (int n = 0; n < PRESSURE_CELLS; n++) begin
            if (n == 16) begin
                hold_request = 1'b1;
            end
            offer_cell(random_cell(50));
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Random cells under a range of settings, extremes first.
    task automatic test_random_phases();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       set_config('0, '0, '0, 32'h0000_0000, 32'h0000_0000);
                1:       set_config(C_MAX, C_MAX, C_MAX, 32'h0000_00FF, 32'h0000_00FF);
                2:       set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                    32'h0000_0080, 32'h0000_0001);
                3:       set_config(random_courant(), random_courant(), random_courant(),
                                    32'h0000_0001, 32'h0000_0080);
                default: set_config(random_courant(), random_courant(), random_courant(),
                                    random_dim_word(), random_dim_word());
            endcase
            no_idle = (phase == 4);
            repeat (PHASE_CELLS) offer_cell(random_cell(75));
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // Receiver side: random ready, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: scalar_out %0d, updated %0b",
                         $time, o_scalar_out, o_updated);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_scalar_out !== want.scalar) begin
                    $display("%0t: scalar_out mismatch: expected %0d, actual %0d",
                             $time, want.scalar, o_scalar_out);
                    fail_count++;
                end
                if (o_updated !== want.updated) begin
                    $display("%0t: updated mismatch: expected %0b, actual %0b",
                             $time, want.updated, o_updated);
                    fail_count++;
                end
            end
        end
    end

    // Hard limit on the run.
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_cases();
        test_stall_pressure();
        test_random_phases();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/upw_pkg.sv
src/upw_ring.sv
src/upw_engine.sv
src/upwind_advection_stencil_3d.sv
test/testbench.sv
